// File: src/lce_pkg.sv
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types, widths and the short-code function for the Levenshtein encoder.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int VALUE_W        = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CODE_W         = 44;
  localparam int LEN_W          = 6;
  localparam int FLEN_W         = 5;   // first field length, 0..31
  localparam int SCODE_W        = 12;  // code of a 5-bit length, at most 12 bits
  localparam int SLEN_W         = 4;
  localparam int HEAD_W         = SCODE_W + 1;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [FLEN_W-1:0]  flen;
    logic [VALUE_W-1:0] value;
  } msb_t;

  typedef struct packed {
    logic               valid;
    logic [FLEN_W-1:0]  flen;
    logic [HEAD_W-1:0]  head;
    logic [SLEN_W-1:0]  head_len;
    logic [VALUE_W-1:0] field;
  } head_t;

  typedef struct packed {
    logic [SCODE_W-1:0] code;
    logic [SLEN_W-1:0]  len;
  } small_code_t;

  // Levenshtein code of a value 0..31
  function automatic small_code_t lev_small(input logic [FLEN_W-1:0] x);
    small_code_t       r;
    logic [SCODE_W-1:0] code;
    logic [SCODE_W-1:0] pmask;
    logic [SLEN_W-1:0]  len;
    logic [2:0]         passes;
    logic [FLEN_W-1:0]  cur;
    logic [FLEN_W-1:0]  fmask;
    logic [2:0]         fl;
    logic               done;
    code   = '0;
    len    = '0;
    passes = '0;
    cur    = x;
    done   = (x == '0);
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        fl = '0;
        for (int j = 0; j < FLEN_W; j++) begin
          if (cur[j]) fl = 3'(j);
        end
        fmask  = (FLEN_W'(1) << fl) - FLEN_W'(1);
        code   = code | (SCODE_W'(cur & fmask) << len);
        len    = len + SLEN_W'(fl);
        passes = passes + 3'd1;
        if (fl == 3'd0) done = 1'b1;
        cur = FLEN_W'(fl);
      end
    end
    if (x == '0) begin
      r.code = '0;
      r.len  = SLEN_W'(1);
    end else begin
      pmask  = (SCODE_W'(1) << passes) - SCODE_W'(1);
      r.code = code | (pmask << (len + SLEN_W'(1)));
      r.len  = len + SLEN_W'(passes) + SLEN_W'(1);
    end
    return r;
  endfunction

endpackage

// File: src/lce_msb_stage.sv
// ----------------------------------------------------------------------------
// lce_msb_stage
// Masks the input value and finds the length of its first field.
// ----------------------------------------------------------------------------
module lce_msb_stage #(
  parameter int VALUE_BITS = lce_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  logic [lce_pkg::VALUE_W-1:0] in_value,
  output lce_pkg::msb_t               s1_o
);

  lce_pkg::msb_t               s1_r, s1_nxt;
  logic [lce_pkg::VALUE_W-1:0] vmask;
  logic [lce_pkg::VALUE_W-1:0] v;

  assign vmask = lce_pkg::VALUE_W'({VALUE_BITS{1'b1}});
  assign v     = in_value & vmask;

  always_comb begin
    s1_nxt       = s1_r;
    s1_nxt.valid = in_take;
    s1_nxt.value = v;
    s1_nxt.zero  = (v == '0);
    s1_nxt.flen  = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (v[i]) s1_nxt.flen = lce_pkg::FLEN_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.zero  <= s1_nxt.zero;
    s1_r.flen  <= s1_nxt.flen;
    s1_r.value <= s1_nxt.value;
  end

  assign s1_o = s1_r;

endmodule

// File: src/lce_head_stage.sv
// ----------------------------------------------------------------------------
// lce_head_stage
// Looks up the code of the first field length and extracts the first field.
// ----------------------------------------------------------------------------
module lce_head_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  lce_pkg::msb_t  s1_i,
  output lce_pkg::head_t s2_o
);

  lce_pkg::head_t              s2_r, s2_nxt;
  lce_pkg::small_code_t        sc;
  logic [lce_pkg::VALUE_W-1:0] fmask;

  assign sc    = lce_pkg::lev_small(s1_i.flen);
  assign fmask = (lce_pkg::VALUE_W'(1) << s1_i.flen) - lce_pkg::VALUE_W'(1);

  always_comb begin
    s2_nxt.valid = s1_i.valid;
    s2_nxt.flen  = s1_i.flen;
    s2_nxt.field = s1_i.value & fmask;
    if (s1_i.zero) begin
      // zero codes as a lone 0
      s2_nxt.head     = '0;
      s2_nxt.head_len = lce_pkg::SLEN_W'(1);
    end else begin
      // leading 1, then the code of the field length
      s2_nxt.head     = (lce_pkg::HEAD_W'(1) << sc.len) | lce_pkg::HEAD_W'(sc.code);
      s2_nxt.head_len = sc.len + lce_pkg::SLEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.flen     <= s2_nxt.flen;
    s2_r.head     <= s2_nxt.head;
    s2_r.head_len <= s2_nxt.head_len;
    s2_r.field    <= s2_nxt.field;
  end

  assign s2_o = s2_r;

endmodule

// File: src/lce_merge_stage.sv
// ----------------------------------------------------------------------------
// lce_merge_stage
// Shifts the head past the first field, merges them and registers the result.
// ----------------------------------------------------------------------------
module lce_merge_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lce_pkg::head_t             s2_i,
  output logic                       out_valid,
  output logic [lce_pkg::CODE_W-1:0] out_codeword,
  output logic [lce_pkg::LEN_W-1:0]  out_code_length
);

  logic                       valid_r, valid_nxt;
  logic [lce_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [lce_pkg::LEN_W-1:0]  len_r, len_nxt;

  assign valid_nxt = s2_i.valid;
  assign code_nxt  = (lce_pkg::CODE_W'(s2_i.head) << s2_i.flen)
                   | lce_pkg::CODE_W'(s2_i.field);
  assign len_nxt   = lce_pkg::LEN_W'(s2_i.head_len) + lce_pkg::LEN_W'(s2_i.flen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    code_r <= code_nxt;
    len_r  <= len_nxt;
  end

  assign out_valid       = valid_r;
  assign out_codeword    = code_r;
  assign out_code_length = len_r;

endmodule

// File: src/levenshtein_code_encoder_unit.sv
// ----------------------------------------------------------------------------
// levenshtein_code_encoder_unit
// Levenshtein universal code encoder, three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  ports                                   transaction when
//  input    start, busy, in_value                   start && !busy
//  result   out_valid, out_codeword, out_code_length out_valid
//
//  One transaction per cycle; a result passes the s1, s2 and output registers.
//  Stages: msb search, length-code lookup and field mask, shift and merge.
//  Reset (rst_n, synchronous) clears the stage valid bits only.
//  busy stays low: the result side cannot stall, so nothing ever backs up.
// ----------------------------------------------------------------------------
module levenshtein_code_encoder_unit #(
  parameter int VALUE_BITS = lce_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lce_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  output logic [lce_pkg::CODE_W-1:0]  out_codeword,
  output logic [lce_pkg::LEN_W-1:0]   out_code_length
);

  lce_pkg::msb_t  s1;
  lce_pkg::head_t s2;
  logic           in_take;

  assign busy    = 1'b0;
  assign in_take = start && !busy;

  lce_msb_stage #(
    .VALUE_BITS (VALUE_BITS)
  ) u_msb (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_value (in_value),
    .s1_o     (s1)
  );

  lce_head_stage u_head (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  lce_merge_stage u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .s2_i            (s2),
    .out_valid       (out_valid),
    .out_codeword    (out_codeword),
    .out_code_length (out_code_length)
  );

endmodule

// File: sim/lce_checker.sv
// ----------------------------------------------------------------------------
// lce_checker
// Watches the encoder's input and result channels. It computes the expected
// Levenshtein codeword for every accepted value and compares each result
// strobe, field by field, against the oldest outstanding codeword.
// ----------------------------------------------------------------------------
module lce_checker #(
  parameter int VALUE_BITS = lce_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lce_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic [lce_pkg::CODE_W-1:0]  out_codeword,
  input  logic [lce_pkg::LEN_W-1:0]   out_code_length,
  output int                          n_fail,
  output int                          n_pending,
  output int                          n_checked,
  output int                          max_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lce_pkg::CODE_W-1:0] codeword;
    logic [lce_pkg::LEN_W-1:0]  code_len;
  } lev_code_t;

  lev_code_t pending_codes[$];

  function automatic lev_code_t lev_encode(input logic [lce_pkg::VALUE_W-1:0] raw);
    lev_code_t   r;
    logic [63:0] acc;
    logic [63:0] cur;
    int          pos;
    int          flen;
    int          passes;
    bit          done;
    cur    = 64'(raw) & ((64'd1 << VALUE_BITS) - 64'd1);
    acc    = '0;
    pos    = 0;
    passes = 0;
    done   = 1'b0;
    if (cur == '0) begin
      r.codeword = '0;
      r.code_len = lce_pkg::LEN_W'(1);
      return r;
    end
    // fields go in from the first pass (lowest bits) upward
    while (!done) begin
      flen = 0;
      for (int i = 0; i < 64; i++) begin
        if (cur[i]) flen = i;
      end
      acc    = acc | ((cur & ((64'd1 << flen) - 64'd1)) << pos);
      pos    = pos + flen;
      passes = passes + 1;
      if (flen == 0) done = 1'b1;
      else cur = 64'(flen);
    end
    acc        = acc | (((64'd1 << passes) - 64'd1) << (pos + 1));
    pos        = pos + passes + 1;
    r.codeword = acc[lce_pkg::CODE_W-1:0];
    r.code_len = lce_pkg::LEN_W'(pos);
    return r;
  endfunction

  always @(posedge clk) begin
    lev_code_t want;
    if (rst_n) begin
      if (start && !busy) pending_codes.push_back(lev_encode(in_value));
      if (out_valid) begin
        if (pending_codes.size() == 0) begin
          n_fail = n_fail + 1;
          if (n_fail <= 10)
            $display("%0t: unexpected result codeword=%h len=%0d",
                     $realtime, out_codeword, out_code_length);
        end else begin
          want      = pending_codes.pop_front();
          n_checked = n_checked + 1;
          if (int'(out_code_length) > max_len) max_len = int'(out_code_length);
          if (out_codeword !== want.codeword || out_code_length !== want.code_len) begin
            n_fail = n_fail + 1;
            if (n_fail <= 10)
              $display("%0t: mismatch codeword exp=%h act=%h len exp=%0d act=%0d",
                       $realtime, want.codeword, out_codeword,
                       want.code_len, out_code_length);
          end
        end
      end
      n_pending = pending_codes.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Levenshtein encoder. Directed boundary values
// are followed by random values of every bit width, with random gaps between
// transactions and stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [lce_pkg::VALUE_W-1:0] in_value;
  logic                        out_valid;
  logic [lce_pkg::CODE_W-1:0]  out_codeword;
  logic [lce_pkg::LEN_W-1:0]   out_code_length;

  int n_fail;
  int n_pending;
  int n_checked;
  int max_len;
  int n_sent;

  levenshtein_code_encoder_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_codeword    (out_codeword),
    .out_code_length (out_code_length)
  );

  lce_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_codeword    (out_codeword),
    .out_code_length (out_code_length),
    .n_fail          (n_fail),
    .n_pending       (n_pending),
    .n_checked       (n_checked),
    .max_len         (max_len)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_value(input logic [lce_pkg::VALUE_W-1:0] v, input int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    in_value = v;
    do @(posedge clk); while (busy);
    n_sent = n_sent + 1;
    @(negedge clk);
  endtask

  function automatic logic [lce_pkg::VALUE_W-1:0] rand_value();
    logic [lce_pkg::VALUE_W-1:0] v;
    int                          w;
    case ($urandom_range(3, 0))
      0: v = $urandom;
      1: begin
        w = $urandom_range(lce_pkg::VALUE_W, 1);
        v = $urandom;
        v = (v & lce_pkg::VALUE_W'((64'd1 << w) - 64'd1))
          | (lce_pkg::VALUE_W'(1) << (w - 1));
      end
      2: v = $urandom_range(40, 0);
      default: begin
        w = $urandom_range(lce_pkg::VALUE_W - 1, 0);
        v = (lce_pkg::VALUE_W'(1) << w) - lce_pkg::VALUE_W'($urandom_range(1, 0));
      end
    endcase
    return v;
  endfunction

  // boundary values: zero, the code-length steps from 1 to 32 and at 2^16 and 2^31, the longest codeword
  logic [lce_pkg::VALUE_W-1:0] corner_values[] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0004, 32'h0000_0007, 32'h0000_0008, 32'h0000_000F,
    32'h0000_0010, 32'h0000_001F, 32'h0000_0020, 32'h0000_FFFF,
    32'h0001_0000, 32'h0001_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    n_sent   = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_values[i]) send_value(corner_values[i], (i % 2 == 0) ? 0 : 3);

    // drain completely before the random traffic
    start = 1'b0;
    wait (n_pending == 0);
    @(negedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 222; k++) send_value(rand_value(), (phase % 2 == 0) ? 5 : 0);
      if ($urandom_range(1, 0) == 1) begin
        start = 1'b0;
        wait (n_pending == 0);
        @(negedge clk);
      end
    end

    start = 1'b0;
    wait (n_pending == 0);
    repeat (10) @(posedge clk);

    $display("tb_top: %0d values sent, %0d codewords compared, longest code %0d bits",
             n_sent, n_checked, max_len);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: timeout after %0d values", n_sent);
    $display("tb_top: errors");
    $finish;
  end

endmodule
